// ===== sv/rtcp_pkg.sv =====
`default_nettype none

package rtcp_pkg;

    // Largest packet piece one item produces (a report block).
    localparam int unsigned PKT_BYTES   = 24;
    localparam int unsigned BUF_W       = PKT_BYTES * 8;
    localparam int unsigned CNT_W       = $clog2(PKT_BYTES + 1);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] func_t;
    localparam func_t FUNC_START = 2'd0;
    localparam func_t FUNC_INFO  = 2'd1;
    localparam func_t FUNC_BLOCK = 2'd2;

    typedef logic [2:0] err_t;
    localparam err_t ERR_NONE       = 3'd0;
    localparam err_t ERR_SENDER_ZERO = 3'd1;
    localparam err_t ERR_BLOCK_ZERO = 3'd2;
    localparam err_t ERR_LOSS_RANGE = 3'd3;
    localparam err_t ERR_ORDER      = 3'd4;

    localparam logic [7:0]  HDR_VERSION = 8'h80;
    localparam logic [7:0]  PT_SR       = 8'd200;
    localparam logic [7:0]  PT_RR       = 8'd201;
    localparam logic [15:0] LEN_SR_BASE = 16'd6;
    localparam logic [15:0] LEN_RR_BASE = 16'd1;

    localparam logic [CNT_W-1:0] BYTES_HDR   = CNT_W'(8);
    localparam logic [CNT_W-1:0] BYTES_INFO  = CNT_W'(20);
    localparam logic [CNT_W-1:0] BYTES_BLOCK = CNT_W'(24);
    localparam logic [CNT_W-1:0] BYTES_ERR   = CNT_W'(1);

    // One unit of work for the serializer: bytes left-aligned, first byte on top.
    typedef struct packed {
        logic [BUF_W-1:0] data;
        logic [CNT_W-1:0] nbytes;
        logic             last;
        err_t             code;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/rtcp_front.sv =====
`default_nettype none

module rtcp_front
    import rtcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] ssrc,
    input  wire logic        is_sender_report,
    input  wire logic [4:0]  block_count,
    input  wire logic [31:0] info_word0,
    input  wire logic [31:0] info_word1,
    input  wire logic [31:0] info_word2,
    input  wire logic [31:0] info_word3,
    input  wire logic [31:0] info_word4,
    input  wire logic [7:0]  lost_fraction,
    input  wire logic signed [31:0] total_lost,
    input  wire logic        queue_full,
    output cmd_t             cmd,
    output logic             cmd_push
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_INFO   = 3'b010,
        PH_BLOCKS = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [4:0] blocks_left_reg, blocks_left_next;

    logic        accept;
    logic [7:0]  cnt_x6;
    logic [15:0] len;
    logic        loss_ok;
    logic [4:0]  blocks_dec;

    assign accept   = push && !queue_full;
    assign cmd_push = accept;

    assign cnt_x6     = {1'b0, block_count, 2'b00} + {2'b00, block_count, 1'b0};
    assign len        = (is_sender_report ? LEN_SR_BASE : LEN_RR_BASE) + {8'd0, cnt_x6};
    assign loss_ok    = (&total_lost[31:23]) || !(|total_lost[31:23]);
    assign blocks_dec = blocks_left_reg - 5'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        blocks_left_next = blocks_left_reg;
        cmd.data         = '0;
        cmd.nbytes       = BYTES_ERR;
        cmd.last         = 1'b1;
        cmd.code         = ERR_ORDER;

        case (func)
            FUNC_START:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    cmd.code = ERR_ORDER;
                end
                else if (ssrc == 32'd0)
                begin
                    cmd.code = ERR_SENDER_ZERO;
                end
                else
                begin
                    cmd.code   = ERR_NONE;
                    cmd.nbytes = BYTES_HDR;
                    cmd.data   = {HDR_VERSION | {3'd0, block_count},
                                  is_sender_report ? PT_SR : PT_RR,
                                  len, ssrc, 128'd0};
                    cmd.last   = !is_sender_report && (block_count == 5'd0);
                end
            end
            FUNC_INFO:
            begin
                if (phase_reg == PH_INFO)
                begin
                    cmd.code   = ERR_NONE;
                    cmd.nbytes = BYTES_INFO;
                    cmd.data   = {info_word0, info_word1, info_word2,
                                  info_word3, info_word4, 32'd0};
                    cmd.last   = (blocks_left_reg == 5'd0);
                end
            end
            FUNC_BLOCK:
            begin
                if (phase_reg != PH_BLOCKS || blocks_left_reg == 5'd0)
                begin
                    cmd.code = ERR_ORDER;
                end
                else if (ssrc == 32'd0)
                begin
                    cmd.code = ERR_BLOCK_ZERO;
                end
                else if (!loss_ok)
                begin
                    cmd.code = ERR_LOSS_RANGE;
                end
                else
                begin
                    cmd.code   = ERR_NONE;
                    cmd.nbytes = BYTES_BLOCK;
                    cmd.data   = {ssrc, lost_fraction, total_lost[23:0],
                                  info_word0, info_word1, info_word2, info_word3};
                    cmd.last   = (blocks_dec == 5'd0);
                end
            end
            default:
            begin
                cmd.code = ERR_ORDER;
            end
        endcase

        if (accept)
        begin
            if (cmd.code != ERR_NONE)
            begin
                phase_next       = PH_IDLE;
                blocks_left_next = 5'd0;
            end
            else
            begin
                case (func)
                    FUNC_START:
                    begin
                        blocks_left_next = block_count;
                        if (is_sender_report)
                            phase_next = PH_INFO;
                        else if (block_count != 5'd0)
                            phase_next = PH_BLOCKS;
                        else
                            phase_next = PH_IDLE;
                    end
                    FUNC_INFO:
                    begin
                        phase_next = (blocks_left_reg != 5'd0) ? PH_BLOCKS : PH_IDLE;
                    end
                    FUNC_BLOCK:
                    begin
                        blocks_left_next = blocks_dec;
                        if (blocks_dec == 5'd0)
                            phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            blocks_left_reg <= 5'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            blocks_left_reg <= blocks_left_next;
        end
    end

    // Any error result is one closing byte.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push && cmd.code != ERR_NONE |-> cmd.nbytes == BYTES_ERR && cmd.last)
        else $error("error command is not a single last byte");

    // Outside a packet no report blocks are owed.
    a_idle_no_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> blocks_left_reg == 5'd0)
        else $error("idle with report blocks outstanding");

endmodule

`default_nettype wire

// ===== sv/rtcp_cmd_queue.sv =====
`default_nettype none

module rtcp_cmd_queue
    import rtcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  cmd_t      wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      rd_valid
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + QCNT_W'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full) && !(rd_en && !rd_valid))
        else $error("command queue overflow or underflow");

endmodule

`default_nettype wire

// ===== sv/rtcp_back.sv =====
`default_nettype none

module rtcp_back
    import rtcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      q_cmd,
    input  wire logic q_valid,
    output logic      q_pop,
    input  wire logic pop,
    output logic      empty,
    output logic [7:0] out_byte,
    output logic      last_byte,
    output logic [2:0] error_code
);

    logic             cur_valid_reg, cur_valid_next;
    logic [BUF_W-1:0] cur_data_reg, cur_data_next;
    logic [CNT_W-1:0] cur_left_reg, cur_left_next;
    logic             cur_last_reg, cur_last_next;
    err_t             cur_code_reg, cur_code_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    err_t             out_code_reg, out_code_next;

    logic advance;
    logic emit;
    logic final_beat;

    assign advance    = !out_valid_reg || pop;
    assign emit       = advance && cur_valid_reg;
    assign final_beat = (cur_left_reg == CNT_W'(1));
    assign q_pop      = q_valid && (!cur_valid_reg || (emit && final_beat));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_data_next  = cur_data_reg;
        cur_left_next  = cur_left_reg;
        cur_last_next  = cur_last_reg;
        cur_code_next  = cur_code_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_code_next  = out_code_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_data_reg[BUF_W-1 -: 8];
            out_last_next  = cur_last_reg && final_beat;
            out_code_next  = cur_code_reg;
            cur_data_next  = {cur_data_reg[BUF_W-9:0], 8'd0};
            cur_left_next  = cur_left_reg - CNT_W'(1);
            if (final_beat)
                cur_valid_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_data_next  = q_cmd.data;
            cur_left_next  = q_cmd.nbytes;
            cur_last_next  = q_cmd.last;
            cur_code_next  = q_cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_data_reg <= cur_data_next;
        cur_left_reg <= cur_left_next;
        cur_last_reg <= cur_last_next;
        cur_code_reg <= cur_code_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_code_reg <= out_code_next;
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last_byte  = out_last_reg;
    assign error_code = out_code_reg;

    // An error result is a zero byte that closes the stream.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error_code != ERR_NONE |-> out_byte == 8'd0 && last_byte)
        else $error("error beat carries data or is not last");

endmodule

`default_nettype wire

// ===== sv/rtcp_report_packet_writer.sv =====
`default_nettype none

// RTCP report packet writer. Items describing one sender report (type 200)
// or receiver report (type 201) go in through a queue-style push/full port,
// and the packet comes out one big-endian byte per beat through an
// empty/pop port. A start item produces the 4-byte header and the sender
// SSRC (8 beats), a sender-info item 20 beats, and each report block 24
// beats with the cumulative loss packed to 24 bits; the final byte of the
// packet has last_byte set. A zero SSRC, a cumulative loss that does not
// fit 24 signed bits, or an item that arrives out of order produces a
// single beat with out_byte zero, last_byte set and a nonzero error_code,
// and the writer drops back to waiting for a start item; bytes that left
// earlier are not taken back. The front end checks and formats an item in
// the cycle it is accepted, so it takes one item per cycle as long as the
// two-entry command queue has room. The serializer behind the queue sends
// one byte per cycle while the output is not stalled, so the sustained rate
// is set by the output stream. Successive commands run back to back on the
// output without gaps, and the first byte of an item passes through the
// command queue, the serializer's current-command register and the output
// register.

module rtcp_report_packet_writer
    import rtcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] ssrc,
    input  wire logic        is_sender_report,
    input  wire logic [4:0]  block_count,
    input  wire logic [31:0] info_word0,
    input  wire logic [31:0] info_word1,
    input  wire logic [31:0] info_word2,
    input  wire logic [31:0] info_word3,
    input  wire logic [31:0] info_word4,
    input  wire logic [7:0]  lost_fraction,
    input  wire logic signed [31:0] total_lost,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last_byte,
    output logic [2:0]       error_code
);

    cmd_t front_cmd;
    logic front_push;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    // The front end owns the packet phase and the count of blocks still owed.
    rtcp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .func             (func),
        .ssrc             (ssrc),
        .is_sender_report (is_sender_report),
        .block_count      (block_count),
        .info_word0       (info_word0),
        .info_word1       (info_word1),
        .info_word2       (info_word2),
        .info_word3       (info_word3),
        .info_word4       (info_word4),
        .lost_fraction    (lost_fraction),
        .total_lost       (total_lost),
        .queue_full       (full),
        .cmd              (front_cmd),
        .cmd_push         (front_push)
    );

    // Formatted commands wait here so input and output can stall apart.
    rtcp_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (q_cmd),
        .rd_valid (q_valid)
    );

    // The serializer shifts bytes out through a registered output stage.
    rtcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_cmd      (q_cmd),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .error_code (error_code)
    );

endmodule

`default_nettype wire

// ===== sim/rtcp_byte_stream_checker.sv =====
`timescale 1ns / 100ps

// Watches both queue ports of the report packet writer, works out the bytes
// each accepted item must produce and compares every popped beat with them.
module rtcp_byte_stream_checker
    import rtcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] ssrc,
    input  wire logic        is_sender_report,
    input  wire logic [4:0]  block_count,
    input  wire logic [31:0] info_word0,
    input  wire logic [31:0] info_word1,
    input  wire logic [31:0] info_word2,
    input  wire logic [31:0] info_word3,
    input  wire logic [31:0] info_word4,
    input  wire logic [7:0]  lost_fraction,
    input  wire logic [31:0] total_lost,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [7:0]  out_byte,
    input  wire logic        last_byte,
    input  wire logic [2:0]  error_code,
    output int               mismatches,
    output int               bytes_outstanding,
    output int               beats_checked,
    output int               error_beats,
    output int               packets_closed
);

    typedef enum logic [1:0] {AWAIT_START, AWAIT_INFO, AWAIT_BLOCKS} phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        err_t       code;
    } beat_t;

    beat_t      expected_beats[$];
    phase_t     phase = AWAIT_START;
    logic [4:0] blocks_left = '0;

    function automatic void add_byte(input logic [7:0] b);
        beat_t nb;
        nb.data = b;
        nb.last = 1'b0;
        nb.code = ERR_NONE;
        expected_beats = {expected_beats, nb};
    endfunction

    function automatic void add_word(input logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    // The byte just queued is the final one of the packet.
    function automatic void close_packet();
        beat_t tail;
        tail = expected_beats[expected_beats.size() - 1];
        tail.last = 1'b1;
        expected_beats[expected_beats.size() - 1] = tail;
        phase = AWAIT_START;
    endfunction

    function automatic void reject(input err_t code);
        beat_t nb;
        nb.data = 8'h00;
        nb.last = 1'b1;
        nb.code = code;
        expected_beats = {expected_beats, nb};
        phase = AWAIT_START;
        blocks_left = '0;
    endfunction

    function automatic void serialize_item();
        logic [15:0] words_len;
        case (func)
            FUNC_START:
            begin
                if (phase != AWAIT_START)
                    reject(ERR_ORDER);
                else if (ssrc == 32'd0)
                    reject(ERR_SENDER_ZERO);
                else
                begin
                    words_len = (is_sender_report ? LEN_SR_BASE : LEN_RR_BASE)
                              + {11'd0, block_count} * 16'd6;
                    add_byte(HDR_VERSION | {3'd0, block_count});
                    add_byte(is_sender_report ? PT_SR : PT_RR);
                    add_byte(words_len[15:8]);
                    add_byte(words_len[7:0]);
                    add_word(ssrc);
                    blocks_left = block_count;
                    if (is_sender_report)
                        phase = AWAIT_INFO;
                    else if (block_count != 5'd0)
                        phase = AWAIT_BLOCKS;
                    else
                        close_packet();
                end
            end
            FUNC_INFO:
            begin
                if (phase != AWAIT_INFO)
                    reject(ERR_ORDER);
                else
                begin
                    add_word(info_word0);
                    add_word(info_word1);
                    add_word(info_word2);
                    add_word(info_word3);
                    add_word(info_word4);
                    if (blocks_left != 5'd0)
                        phase = AWAIT_BLOCKS;
                    else
                        close_packet();
                end
            end
            FUNC_BLOCK:
            begin
                if (phase != AWAIT_BLOCKS || blocks_left == 5'd0)
                    reject(ERR_ORDER);
                else if (ssrc == 32'd0)
                    reject(ERR_BLOCK_ZERO);
                else if (total_lost[31:23] != {9{total_lost[31]}})
                    reject(ERR_LOSS_RANGE);
                else
                begin
                    add_word(ssrc);
                    add_byte(lost_fraction);
                    add_byte(total_lost[23:16]);
                    add_byte(total_lost[15:8]);
                    add_byte(total_lost[7:0]);
                    add_word(info_word0);
                    add_word(info_word1);
                    add_word(info_word2);
                    add_word(info_word3);
                    blocks_left = blocks_left - 5'd1;
                    if (blocks_left == 5'd0)
                        close_packet();
                end
            end
            default:
                reject(ERR_ORDER);
        endcase
    endfunction

    function automatic void check_beat();
        beat_t want;
        beats_checked++;
        if (error_code != ERR_NONE)
            error_beats++;
        if (last_byte)
            packets_closed++;
        if (expected_beats.size() == 0)
        begin
            if (mismatches < 10)
                $display("%t MISMATCH: unexpected beat byte=%h last=%b code=%0d",
                         $realtime, out_byte, last_byte, error_code);
            mismatches++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (out_byte !== want.data || last_byte !== want.last
                || error_code !== want.code)
            begin
                if (mismatches < 10)
                    $display("%t MISMATCH: byte %h/%h last %b/%b code %0d/%0d (exp/act)",
                             $realtime, want.data, out_byte, want.last, last_byte,
                             want.code, error_code);
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            phase = AWAIT_START;
            blocks_left = '0;
            mismatches = 0;
            beats_checked = 0;
            error_beats = 0;
            packets_closed = 0;
            bytes_outstanding = 0;
        end
        else
        begin
            if (push && !full)
                serialize_item();
            if (pop && !empty)
                check_beat();
            bytes_outstanding = expected_beats.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Top of the testbench for the RTCP report packet writer. This module only
// makes stimulus and gives the verdict; the checker beside the block does
// all prediction and comparison.
module tb;
    import rtcp_pkg::*;

    // The func code that the block does not define; it must be rejected as
    // out of order.
    localparam func_t FUNC_SPARE = 2'd3;

    // One input item as the sender sees it. Fields that the operation does not
    // use are still filled with random values so that they act as noise.
    typedef struct packed {
        func_t           func;
        logic [31:0]     ssrc;
        logic            is_sender_report;
        logic [4:0]      block_count;
        logic [4:0][31:0] words;
        logic [7:0]      lost_fraction;
        logic [31:0]     total_lost;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  func;
    logic [31:0] ssrc;
    logic        is_sender_report;
    logic [4:0]  block_count;
    logic [31:0] info_word0;
    logic [31:0] info_word1;
    logic [31:0] info_word2;
    logic [31:0] info_word3;
    logic [31:0] info_word4;
    logic [7:0]  lost_fraction;
    logic signed [31:0] total_lost;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [2:0]  error_code;

    int mismatches;
    int bytes_outstanding;
    int beats_checked;
    int error_beats;
    int packets_closed;

    // Sender pacing: items go out in bursts, with idle gaps between them.
    int burst_left = 0;
    int items_sent = 0;

    // Receiver pacing state.
    int stall_mode;
    int stall_span;

    rtcp_report_packet_writer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .func             (func),
        .ssrc             (ssrc),
        .is_sender_report (is_sender_report),
        .block_count      (block_count),
        .info_word0       (info_word0),
        .info_word1       (info_word1),
        .info_word2       (info_word2),
        .info_word3       (info_word3),
        .info_word4       (info_word4),
        .lost_fraction    (lost_fraction),
        .total_lost       (total_lost),
        .empty            (empty),
        .pop              (pop),
        .out_byte         (out_byte),
        .last_byte        (last_byte),
        .error_code       (error_code)
    );

    rtcp_byte_stream_checker u_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .func              (func),
        .ssrc              (ssrc),
        .is_sender_report  (is_sender_report),
        .block_count       (block_count),
        .info_word0        (info_word0),
        .info_word1        (info_word1),
        .info_word2        (info_word2),
        .info_word3        (info_word3),
        .info_word4        (info_word4),
        .lost_fraction     (lost_fraction),
        .total_lost        (total_lost),
        .empty             (empty),
        .pop               (pop),
        .out_byte          (out_byte),
        .last_byte         (last_byte),
        .error_code        (error_code),
        .mismatches        (mismatches),
        .bytes_outstanding (bytes_outstanding),
        .beats_checked     (beats_checked),
        .error_beats       (error_beats),
        .packets_closed    (packets_closed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A fully random item: any func, including the spare code.
    function automatic item_t noise_item();
        item_t it;
        it.func             = func_t'($urandom_range(0, 3));
        it.ssrc             = $urandom();
        it.is_sender_report = 1'($urandom_range(0, 1));
        it.block_count      = 5'($urandom_range(0, 31));
        for (int i = 0; i < 5; i++)
            it.words[i] = $urandom();
        it.lost_fraction    = 8'($urandom());
        it.total_lost       = $urandom();
        return it;
    endfunction

    function automatic item_t start_item(input logic sr, input logic [4:0] cnt,
                                         input logic [31:0] sender);
        item_t it;
        it = noise_item();
        it.func = FUNC_START;
        it.is_sender_report = sr;
        it.block_count = cnt;
        it.ssrc = sender;
        return it;
    endfunction

    function automatic item_t info_item();
        item_t it;
        it = noise_item();
        it.func = FUNC_INFO;
        return it;
    endfunction

    function automatic item_t block_item(input logic [31:0] source, input logic [7:0] frac,
                                         input logic [31:0] loss);
        item_t it;
        it = noise_item();
        it.func = FUNC_BLOCK;
        it.ssrc = source;
        it.lost_fraction = frac;
        it.total_lost = loss;
        return it;
    endfunction

    // Mostly a legal 24-bit loss, now and then a boundary value on either side
    // of the signed 24-bit range or a raw 32-bit value that usually overflows.
    function automatic logic [31:0] pick_loss();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: pick_loss = raw;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: pick_loss = 32'sd8388607;
                    1: pick_loss = -32'sd8388608;
                    2: pick_loss = 32'sd8388608;
                    3: pick_loss = -32'sd8388609;
                    4: pick_loss = 32'h7fff_ffff;
                    default: pick_loss = 32'h8000_0000;
                endcase
            end
            default: pick_loss = {{8{raw[23]}}, raw[23:0]};
        endcase
    endfunction

    // A nonzero SSRC nearly always; a zero one once in a while to hit the
    // zero-SSRC error paths.
    function automatic logic [31:0] pick_ssrc();
        logic [31:0] s;
        s = $urandom();
        if ($urandom_range(0, 29) == 0)
            s = 32'd0;
        else if (s == 32'd0)
            s = 32'd1;
        return s;
    endfunction

    // Present one item and hold it until the block takes it. The task is
    // entered and left at a falling edge. When a burst runs out, push drops
    // for a random number of cycles (possibly none) before the next burst.
    task automatic offer(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            push = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        func             = it.func;
        ssrc             = it.ssrc;
        is_sender_report = it.is_sender_report;
        block_count      = it.block_count;
        info_word0       = it.words[0];
        info_word1       = it.words[1];
        info_word2       = it.words[2];
        info_word3       = it.words[3];
        info_word4       = it.words[4];
        lost_fraction    = it.lost_fraction;
        total_lost       = it.total_lost;
        push             = 1'b1;
        // full is a registered output, so its pre-edge value is what we read here.
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        burst_left--;
        @(negedge clk);
        push = 1'b0;
    endtask

    // A report packet with random content. Most packets are whole; about one
    // in ten is cut short so that the following start lands out of order.
    task automatic send_random_packet();
        logic       sr;
        logic [4:0] cnt;
        int         total;
        int         keep;
        sr = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 24) == 0)
            cnt = 5'($urandom_range(0, 31));
        else
            cnt = 5'($urandom_range(0, 3));
        total = 1 + int'(sr) + int'(cnt);
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
        for (int k = 0; k < keep; k++)
        begin
            if (k == 0)
                offer(start_item(sr, cnt, pick_ssrc()));
            else if (k == 1 && sr)
                offer(info_item());
            else
                offer(block_item(pick_ssrc(), 8'($urandom()), pick_loss()));
        end
    endtask

    // Hold the sender until every predicted byte has been popped.
    task automatic wait_drained();
        wait (bytes_outstanding == 0);
        @(negedge clk);
    endtask

    // Receiver: pops follow a stall pattern that changes after each random span,
    // from popping every cycle to popping only now and then.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 200);
            repeat (stall_span)
            begin
                @(negedge clk);
                case (stall_mode)
                    0: pop = 1'b1;
                    1: pop = 1'($urandom_range(0, 1));
                    2: pop = ($urandom_range(0, 7) == 0);
                    default: pop = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        item_t it;
        rst_n            = 1'b0;
        push             = 1'b0;
        func             = FUNC_START;
        ssrc             = '0;
        is_sender_report = 1'b0;
        block_count      = '0;
        info_word0       = '0;
        info_word1       = '0;
        info_word2       = '0;
        info_word3       = '0;
        info_word4       = '0;
        lost_fraction    = '0;
        total_lost       = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Sender report with two blocks: all-ones SSRC and info words, then
        // the largest and smallest legal cumulative loss.
        offer(start_item(1'b1, 5'd2, 32'hffff_ffff));
        it = info_item();
        it.words = {5{32'hffff_ffff}};
        offer(it);
        it = block_item(32'd1, 8'hff, 32'sd8388607);
        it.words = '0;
        offer(it);
        offer(block_item(32'hffff_ffff, 8'h00, -32'sd8388608));

        // An empty receiver report ends on the last byte of the SSRC, and a
        // sender report with no blocks ends on the sender info.
        offer(start_item(1'b0, 5'd0, 32'd1));
        offer(start_item(1'b1, 5'd0, $urandom() | 32'd1));
        it = info_item();
        it.words = '0;
        offer(it);

        // Zero sender SSRC, sender info and a block while idle (the block also
        // has a zero SSRC, so ordering must win), and the spare func code.
        offer(start_item(1'b0, 5'd1, 32'd0));
        offer(info_item());
        offer(block_item(32'd0, 8'h12, 32'd0));
        it = noise_item();
        it.func = FUNC_SPARE;
        offer(it);

        // Zero block SSRC takes precedence over a loss that is out of range.
        offer(start_item(1'b0, 5'd31, $urandom() | 32'd1));
        offer(block_item(32'd0, 8'h34, 32'sd8388608));

        // Loss one past either end of the 24-bit range.
        offer(start_item(1'b0, 5'd3, $urandom() | 32'd1));
        offer(block_item($urandom() | 32'd1, 8'h56, 32'sd8388608));
        offer(start_item(1'b0, 5'd1, $urandom() | 32'd1));
        offer(block_item($urandom() | 32'd1, 8'h78, -32'sd8388609));

        // A start while a packet is in progress aborts it.
        offer(start_item(1'b0, 5'd1, $urandom() | 32'd1));
        offer(start_item(1'b1, 5'd4, $urandom() | 32'd1));

        // A block where sender info is due, and a second sender info.
        offer(start_item(1'b1, 5'd1, $urandom() | 32'd1));
        offer(block_item($urandom() | 32'd1, 8'h9a, 32'd5));
        offer(start_item(1'b1, 5'd1, $urandom() | 32'd1));
        offer(info_item());
        offer(info_item());

        // A well-formed receiver report with a loss of minus one.
        offer(start_item(1'b0, 5'd1, $urandom() | 32'd1));
        offer(block_item($urandom() | 32'd1, 8'hbc, 32'hffff_ffff));

        // Let the output run completely dry before random traffic begins.
        wait_drained();

        // Random part: mostly well-formed packets, with some loose noise items
        // mixed in. Halfway through, the sender waits for a full drain once more.
        while (items_sent < 310)
        begin
            if ($urandom_range(0, 6) == 0)
                offer(noise_item());
            else
                send_random_packet();
            if (items_sent >= 160 && items_sent < 170)
                wait_drained();
        end

        wait (bytes_outstanding == 0);
        repeat (40) @(posedge clk);

        $display("Accepted %0d items and checked %0d output beats.",
                 items_sent, beats_checked);
        $display("Seen %0d packet ends, %0d of them error beats; mismatches: %0d.",
                 packets_closed, error_beats, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rtcp_pkg.sv
sv/rtcp_front.sv
sv/rtcp_cmd_queue.sv
sv/rtcp_back.sv
sv/rtcp_report_packet_writer.sv
sim/rtcp_byte_stream_checker.sv
sim/tb.sv
